### design/rbfk_pkg.sv
// shared types and constants for the gaussian rbf kernel unit
// depends on nothing; used by every module of the block
`default_nettype none

package rbfk_pkg;

  localparam int ELEM_W     = 16;
  localparam int SQ_W       = 32;
  localparam int DIST_W     = 41;
  localparam logic [DIST_W-1:0] DIST_TOP = {DIST_W{1'b1}};
  localparam int KV_W       = 16;
  localparam int MAX_DIM    = 256;

  // restoring divide: 4 integer bits plus 32 fraction bits of the exponent
  localparam int DIV_STEPS  = 36;
  localparam int DVS_W      = 37;
  localparam int CNT_W      = 6;
  localparam int LAST_TERM  = 13;
  localparam int SQUARINGS  = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] sample_elem;
    logic signed [ELEM_W-1:0] ref_elem;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [KV_W-1:0] kernel_value;
    logic            sigma_zero;
    logic            dist_saturated;
  } out_item_t;

  // one finished row handed from front to back
  typedef struct packed {
    logic [DIST_W-1:0] row_sum;
    logic              overflowed;
  } row_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQ,
    BK_CHK,
    BK_DIV,
    BK_SINIT,
    BK_MULT,
    BK_MULK,
    BK_CORR,
    BK_CAP,
    BK_SQMUL,
    BK_SQRND,
    BK_RND,
    BK_DONE
  } bk_state_t;

  // floor(2^32 / k) for the series divisors
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] m;
    case (k)
      4'd2:    m = 32'd2147483648;
      4'd3:    m = 32'd1431655765;
      4'd4:    m = 32'd1073741824;
      4'd5:    m = 32'd858993459;
      4'd6:    m = 32'd715827882;
      4'd7:    m = 32'd613566756;
      4'd8:    m = 32'd536870912;
      4'd9:    m = 32'd477218588;
      4'd10:   m = 32'd429496729;
      4'd11:   m = 32'd390451572;
      4'd12:   m = 32'd357913941;
      4'd13:   m = 32'd330382099;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### design/rbfk_front.sv
// front end: takes element pairs, squares the difference and keeps the row sum
// depends on rbfk_pkg
`default_nettype none

module rbfk_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rbfk_pkg::in_item_t  in_data,
  input  wire rbfk_pkg::queue_status_t q_stat,
  output logic                     push,
  output rbfk_pkg::row_entry_t     push_entry
);

  logic                      a_valid_r, a_valid_nxt;
  logic                      a_last_r;
  logic [rbfk_pkg::SQ_W-1:0] a_sq_r;
  logic [rbfk_pkg::DIST_W-1:0] sum_r, sum_nxt;
  logic                      ovf_r, ovf_nxt;

  logic signed [rbfk_pkg::ELEM_W:0] diff;
  logic [rbfk_pkg::ELEM_W:0]        diff_abs;
  logic [rbfk_pkg::ELEM_W-1:0]      mag;
  logic                             a_adv;
  logic                             accept;
  logic [rbfk_pkg::DIST_W:0]        sum_wide;
  logic                             sat;
  logic [rbfk_pkg::DIST_W-1:0]      sum_sat;

  always_comb begin
    diff     = {in_data.sample_elem[rbfk_pkg::ELEM_W-1], in_data.sample_elem}
             - {in_data.ref_elem[rbfk_pkg::ELEM_W-1], in_data.ref_elem};
    diff_abs = diff[rbfk_pkg::ELEM_W] ? (-diff) : diff;
    mag      = diff_abs[rbfk_pkg::ELEM_W-1:0];
  end

  // a row end waits here until the queue has room
  assign a_adv    = a_valid_r && (!a_last_r || !q_stat.full);
  assign in_ready = !a_valid_r || a_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    sum_wide = {1'b0, sum_r} + {{(rbfk_pkg::DIST_W + 1 - rbfk_pkg::SQ_W){1'b0}}, a_sq_r};
    sat      = sum_wide[rbfk_pkg::DIST_W];
    sum_sat  = sat ? rbfk_pkg::DIST_TOP : sum_wide[rbfk_pkg::DIST_W-1:0];
  end

  always_comb begin
    a_valid_nxt = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_r);
    sum_nxt     = sum_r;
    ovf_nxt     = ovf_r;
    push        = 1'b0;
    push_entry.row_sum    = sum_sat;
    push_entry.overflowed = ovf_r | sat;
    if (a_adv) begin
      if (a_last_r) begin
        push    = 1'b1;
        sum_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        sum_nxt = sum_sat;
        ovf_nxt = ovf_r | sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      sum_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      sum_r     <= sum_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sq_r   <= mag * mag;
      a_last_r <= in_data.last;
    end
  end

endmodule

`default_nettype wire

### design/rbfk_queue.sv
// small fifo of finished row sums between front and back
// depends on rbfk_pkg
`default_nettype none

module rbfk_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire rbfk_pkg::row_entry_t  push_entry,
  input  wire logic                  pop,
  output rbfk_pkg::row_entry_t       head,
  output rbfk_pkg::queue_status_t    stat
);

  rbfk_pkg::row_entry_t                 mem_r [rbfk_pkg::QUEUE_DEPTH];
  logic [rbfk_pkg::QUEUE_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [rbfk_pkg::QUEUE_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [rbfk_pkg::QUEUE_AW:0]          count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == (rbfk_pkg::QUEUE_AW + 1)'(rbfk_pkg::QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

### design/rbfk_back.sv
// back end: sequencer for divide, exp series and squarings, plus output register
// depends on rbfk_pkg; one shared 32x32 multiplier for sigma^2, series, squarings
`default_nettype none

module rbfk_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [15:0]           sigma,
  input  wire rbfk_pkg::row_entry_t  head,
  input  wire rbfk_pkg::queue_status_t q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rbfk_pkg::out_item_t        out_data
);

  rbfk_pkg::bk_state_t state_r, state_nxt;

  logic [rbfk_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        szero_r, szero_nxt;
  logic [63:0]                 prod_r, prod_nxt;
  logic [rbfk_pkg::DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [rbfk_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [rbfk_pkg::DIV_STEPS-1:0] quo_r, quo_nxt;
  logic [rbfk_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]                 r_r, r_nxt;
  logic [31:0]                 term_r, term_nxt;
  logic [32:0]                 y_r, y_nxt;
  logic [3:0]                  k_r, k_nxt;
  logic [31:0]                 p_r, p_nxt;
  logic [31:0]                 ysq_r, ysq_nxt;
  logic [1:0]                  sqn_r, sqn_nxt;
  logic [rbfk_pkg::KV_W-1:0]   kv_r, kv_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rbfk_pkg::out_item_t         out_r, out_nxt;

  logic [31:0]                 mul_a, mul_b;
  logic [31:0]                 s2;
  logic [rbfk_pkg::DVS_W-1:0]  lim24;
  logic                        too_far;
  logic [rbfk_pkg::DVS_W:0]    rem2;
  logic                        ge;
  logic [rbfk_pkg::DIV_STEPS:0] x_rnd;
  logic [31:0]                 q_est;
  logic [35:0]                 qk;
  logic [35:0]                 q_rem;
  logic [31:0]                 q_fix;
  logic [63:0]                 sq_rnd;
  logic [32:0]                 kv_wide;
  logic                        slot_free;

  assign s2        = prod_r[31:0];
  assign lim24     = {1'b0, s2, 4'b0} + {2'b0, s2, 3'b0};
  assign too_far   = dist_r >= {{(rbfk_pkg::DIST_W - rbfk_pkg::DVS_W){1'b0}}, lim24};
  assign rem2      = {rem_r, 1'b0};
  assign ge        = rem2 >= {1'b0, dvs_r};
  assign x_rnd     = {1'b0, quo_r} + (rbfk_pkg::DIV_STEPS + 1)'(8);
  assign q_est     = prod_r[63:32];
  assign qk        = q_est * k_r;
  assign q_rem     = {4'b0, p_r} - qk;
  assign q_fix     = (q_rem >= {32'b0, k_r}) ? q_est + 32'd1 : q_est;
  assign sq_rnd    = prod_r + 64'h0000_0000_8000_0000;
  assign kv_wide   = {1'b0, ysq_r} + 33'h0_0000_8000;
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rbfk_pkg::BK_IDLE: begin
        if (q_stat.valid) begin
          state_nxt = (sigma == 16'd0) ? rbfk_pkg::BK_DONE : rbfk_pkg::BK_SQ;
        end
      end
      rbfk_pkg::BK_SQ:    state_nxt = rbfk_pkg::BK_CHK;
      rbfk_pkg::BK_CHK:   state_nxt = too_far ? rbfk_pkg::BK_DONE : rbfk_pkg::BK_DIV;
      rbfk_pkg::BK_DIV: begin
        if (cnt_r == rbfk_pkg::CNT_W'(rbfk_pkg::DIV_STEPS - 1)) begin
          state_nxt = rbfk_pkg::BK_SINIT;
        end
      end
      rbfk_pkg::BK_SINIT: state_nxt = rbfk_pkg::BK_MULT;
      rbfk_pkg::BK_MULT:  state_nxt = rbfk_pkg::BK_MULK;
      rbfk_pkg::BK_MULK:  state_nxt = rbfk_pkg::BK_CORR;
      rbfk_pkg::BK_CORR: begin
        state_nxt = (k_r == 4'(rbfk_pkg::LAST_TERM)) ? rbfk_pkg::BK_CAP : rbfk_pkg::BK_MULT;
      end
      rbfk_pkg::BK_CAP:   state_nxt = rbfk_pkg::BK_SQMUL;
      rbfk_pkg::BK_SQMUL: state_nxt = rbfk_pkg::BK_SQRND;
      rbfk_pkg::BK_SQRND: begin
        state_nxt = (sqn_r == 2'(rbfk_pkg::SQUARINGS - 1)) ? rbfk_pkg::BK_RND
                                                          : rbfk_pkg::BK_SQMUL;
      end
      rbfk_pkg::BK_RND:   state_nxt = rbfk_pkg::BK_DONE;
      rbfk_pkg::BK_DONE: begin
        if (slot_free) begin
          state_nxt = rbfk_pkg::BK_IDLE;
        end
      end
      default:            state_nxt = rbfk_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    dist_nxt  = dist_r;
    ovf_nxt   = ovf_r;
    szero_nxt = szero_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    r_nxt     = r_r;
    term_nxt  = term_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    ysq_nxt   = ysq_r;
    sqn_nxt   = sqn_r;
    kv_nxt    = kv_r;
    mul_a     = term_r;
    mul_b     = r_r;
    prod_nxt  = prod_r;
    pop       = 1'b0;
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      rbfk_pkg::BK_IDLE: begin
        dist_nxt  = head.row_sum;
        ovf_nxt   = head.overflowed;
        szero_nxt = (sigma == 16'd0);
        kv_nxt    = '0;
      end
      rbfk_pkg::BK_SQ: begin
        mul_a    = {16'b0, sigma};
        mul_b    = {16'b0, sigma};
        prod_nxt = mul_a * mul_b;
      end
      rbfk_pkg::BK_CHK: begin
        // divisor 16*2*s^2 so the quotient comes out already scaled by 2^32
        dvs_nxt = {s2, 5'b0};
        rem_nxt = dist_r[rbfk_pkg::DVS_W-1:0];
        cnt_nxt = '0;
        kv_nxt  = '0;
      end
      rbfk_pkg::BK_DIV: begin
        rem_nxt = ge ? rbfk_pkg::DVS_W'(rem2 - {1'b0, dvs_r}) : rem2[rbfk_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[rbfk_pkg::DIV_STEPS-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      rbfk_pkg::BK_SINIT: begin
        // first term of the series is r itself
        r_nxt    = x_rnd[35:4];
        term_nxt = x_rnd[35:4];
        y_nxt    = 33'h1_0000_0000 - {1'b0, x_rnd[35:4]};
        k_nxt    = 4'd2;
      end
      rbfk_pkg::BK_MULT: begin
        mul_a    = term_r;
        mul_b    = r_r;
        prod_nxt = mul_a * mul_b;
      end
      rbfk_pkg::BK_MULK: begin
        p_nxt    = prod_r[63:32];
        mul_a    = prod_r[63:32];
        mul_b    = rbfk_pkg::recip(k_r);
        prod_nxt = mul_a * mul_b;
      end
      rbfk_pkg::BK_CORR: begin
        // reciprocal estimate is low by at most one
        term_nxt = q_fix;
        y_nxt    = k_r[0] ? y_r - {1'b0, q_fix} : y_r + {1'b0, q_fix};
        k_nxt    = k_r + 4'd1;
      end
      rbfk_pkg::BK_CAP: begin
        ysq_nxt = y_r[32] ? 32'hFFFF_FFFF : y_r[31:0];
        sqn_nxt = '0;
      end
      rbfk_pkg::BK_SQMUL: begin
        mul_a    = ysq_r;
        mul_b    = ysq_r;
        prod_nxt = mul_a * mul_b;
      end
      rbfk_pkg::BK_SQRND: begin
        ysq_nxt = sq_rnd[63:32];
        sqn_nxt = sqn_r + 2'd1;
      end
      rbfk_pkg::BK_RND: begin
        kv_nxt = kv_wide[32] ? 16'hFFFF : kv_wide[31:16];
      end
      rbfk_pkg::BK_DONE: begin
        if (slot_free) begin
          pop                    = 1'b1;
          out_valid_nxt          = 1'b1;
          out_nxt.kernel_value   = kv_r;
          out_nxt.sigma_zero     = szero_r;
          out_nxt.dist_saturated = ovf_r;
        end
      end
      default: begin
        kv_nxt = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbfk_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r  <= dist_nxt;
    ovf_r   <= ovf_nxt;
    szero_r <= szero_nxt;
    prod_r  <= prod_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    r_r     <= r_nxt;
    term_r  <= term_nxt;
    y_r     <= y_nxt;
    k_r     <= k_nxt;
    p_r     <= p_nxt;
    ysq_r   <= ysq_nxt;
    sqn_r   <= sqn_nxt;
    kv_r    <= kv_nxt;
    out_r   <= out_nxt;
  end

endmodule

`default_nettype wire

### design/rbf_kernel_eval.sv
// Gaussian RBF kernel unit. The front end takes one element pair per cycle
// while in_ready is high and adds the squared difference into a saturating
// 41-bit Q25.16 sum; a row ends on the item marked last. Each finished row
// goes through a two-entry queue to the back end, which forms
// exp(-d/(2*sigma^2)) in Q0.16: a restoring divider at one bit per cycle, a
// series to the 13th power whose terms 2 to 13 run on one shared 32x32
// multiplier (each term a multiply, a reciprocal multiply and a correction),
// four squarings (each a multiply and a rounding) and a final rounding step.
// Rows that come in faster than the back end finishes them backpressure
// the input once the queue is full. With sigma zero the result is 0 with
// sigma_zero set; an exponent of 12 or more gives 0.
// Write sigma only while no row is in flight.
// depends on rbfk_pkg, rbfk_front, rbfk_queue, rbfk_back
`default_nettype none

module rbf_kernel_eval (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rbfk_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rbfk_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata
);

  logic [15:0]             sigma_r, sigma_nxt;
  logic                    push;
  logic                    pop;
  rbfk_pkg::row_entry_t    push_entry;
  rbfk_pkg::row_entry_t    head;
  rbfk_pkg::queue_status_t q_stat;

  assign sigma_nxt = cfg_we ? cfg_wdata : sigma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= '0;
    end else begin
      sigma_r <= sigma_nxt;
    end
  end

  rbfk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  rbfk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  rbfk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .sigma      (sigma_r),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
